### design/wmmg_pkg.sv
// shared constants and types for the 3x3 window filter
package wmmg_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_CHANNELS = 3;
   localparam int MAX_HEIGHT   = 4096;
   localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
   localparam int LINE_ADDR_W  = $clog2(LINE_DEPTH);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE   = 2'd3;

   localparam logic [1:0] MODE_MEAN   = 2'd0;
   localparam logic [1:0] MODE_MEDIAN = 2'd1;
   localparam logic [1:0] MODE_GAUSS  = 2'd2;
   localparam logic [1:0] MODE_GAUSS_ALT = 2'd3;

   // ceil(65536 / 9), exact floor division for sums up to 9 * 255
   localparam logic [12:0] MEAN_RECIP = 13'd7282;

   typedef struct packed {
      logic [8:0][7:0] pix;
      logic            run_last;
      logic            frame_last;
   } job_type;

endpackage

### design/wmmg_req_if.sv
// input sample channel
interface wmmg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

### design/wmmg_rsp_if.sv
// filtered result channel
interface wmmg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_out;
   logic       run_last;
   logic       frame_last;

   modport source (output valid, output sample_out, output run_last, output frame_last,
                   input ready);
   modport sink   (input valid, input sample_out, input run_last, input frame_last,
                   output ready);
endinterface

### design/wmmg_filter.sv
// filter pipeline: mean, median or gaussian over one 3x3 window per word
module wmmg_filter import wmmg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  job_type    in_job,
   input  logic [1:0] mode,
   wmmg_rsp_if.source rsp_chan
);

   function automatic logic [15:0] sort2(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] r;
      r = (a > b) ? {b, a} : {a, b};
      return r;
   endfunction

   logic    f1_v_ff;
   job_type f1_job_ff;

   logic        f2_v_ff;
   logic [7:0]  f2_p_ff [9];
   logic [11:0] f2_box_ff;
   logic [11:0] f2_gauss_ff;
   logic        f2_run_ff;
   logic        f2_frame_ff;

   logic       rsp_v_ff;
   logic [7:0] rsp_sample_ff;
   logic       rsp_run_ff;
   logic       rsp_frame_ff;

   logic rsp_adv;
   logic f2_take;
   logic f1_take;

   logic [7:0]  p1 [9];
   logic [7:0]  p2 [9];
   logic [11:0] box_in;
   logic [11:0] gauss_in;
   logic [24:0] mean_prod;
   logic [7:0]  result_in;

   assign rsp_adv  = !rsp_v_ff || rsp_chan.ready;
   assign f2_take  = !f2_v_ff || rsp_adv;
   assign f1_take  = !f1_v_ff || f2_take;
   assign in_ready = f1_take;

   // first half of the median network plus both sums
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p1[i] = f1_job_ff.pix[i];
      end
      {p1[1], p1[2]} = sort2(p1[1], p1[2]);
      {p1[4], p1[5]} = sort2(p1[4], p1[5]);
      {p1[7], p1[8]} = sort2(p1[7], p1[8]);
      {p1[0], p1[1]} = sort2(p1[0], p1[1]);
      {p1[3], p1[4]} = sort2(p1[3], p1[4]);
      {p1[6], p1[7]} = sort2(p1[6], p1[7]);
      {p1[1], p1[2]} = sort2(p1[1], p1[2]);
      {p1[4], p1[5]} = sort2(p1[4], p1[5]);
      {p1[7], p1[8]} = sort2(p1[7], p1[8]);

      box_in = '0;
      for (int i = 0; i < 9; i++) begin
         box_in = box_in + 12'(f1_job_ff.pix[i]);
      end
      gauss_in = 12'(f1_job_ff.pix[0]) + 12'(f1_job_ff.pix[2])
               + 12'(f1_job_ff.pix[6]) + 12'(f1_job_ff.pix[8])
               + ((12'(f1_job_ff.pix[1]) + 12'(f1_job_ff.pix[3])
                 + 12'(f1_job_ff.pix[5]) + 12'(f1_job_ff.pix[7])) << 1)
               + (12'(f1_job_ff.pix[4]) << 2);
   end

   // second half of the median network, mean by reciprocal multiply
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p2[i] = f2_p_ff[i];
      end
      {p2[0], p2[3]} = sort2(p2[0], p2[3]);
      {p2[5], p2[8]} = sort2(p2[5], p2[8]);
      {p2[4], p2[7]} = sort2(p2[4], p2[7]);
      {p2[3], p2[6]} = sort2(p2[3], p2[6]);
      {p2[1], p2[4]} = sort2(p2[1], p2[4]);
      {p2[2], p2[5]} = sort2(p2[2], p2[5]);
      {p2[4], p2[7]} = sort2(p2[4], p2[7]);
      {p2[4], p2[2]} = sort2(p2[4], p2[2]);
      {p2[6], p2[4]} = sort2(p2[6], p2[4]);
      {p2[4], p2[2]} = sort2(p2[4], p2[2]);

      mean_prod = 25'(f2_box_ff) * 25'(MEAN_RECIP);
      unique case (mode)
         MODE_MEAN:      result_in = mean_prod[23:16];
         MODE_MEDIAN:    result_in = p2[4];
         MODE_GAUSS:     result_in = f2_gauss_ff[11:4];
         MODE_GAUSS_ALT: result_in = f2_gauss_ff[11:4];
         default:        result_in = f2_gauss_ff[11:4];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff  <= 1'b0;
         f2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (f1_take) begin
            f1_v_ff <= in_valid;
         end
         if (f2_take) begin
            f2_v_ff <= f1_v_ff;
         end
         if (rsp_adv) begin
            rsp_v_ff <= f2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f1_take) begin
         f1_job_ff <= in_job;
      end
      if (f2_take) begin
         f2_p_ff     <= p1;
         f2_box_ff   <= box_in;
         f2_gauss_ff <= gauss_in;
         f2_run_ff   <= f1_job_ff.run_last;
         f2_frame_ff <= f1_job_ff.frame_last;
      end
      if (rsp_adv) begin
         rsp_sample_ff <= result_in;
         rsp_run_ff    <= f2_run_ff;
         rsp_frame_ff  <= f2_frame_ff;
      end
   end

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.run_last   = rsp_run_ff;
   assign rsp_chan.frame_last = rsp_frame_ff;

endmodule

### design/window_3x3_mean_median_gaussian_unit.sv
// 3x3 window image filter top level: line store, window registers, result sequencer
//
//   channel   direction  payload                          handshake
//   req_chan  in         sample_in[7:0]                   valid/ready
//   rsp_chan  out        sample_out[7:0], run_last,       valid/ready
//                        frame_last
//   csr_*     in         csr_index[1:0], csr_wr_data      csr_wr_en, no stall
//
// one word accepted per cycle when stage 1 can move on; a word that causes n results (n up to 4)
// stays in the result sequencer, which issues one window per cycle while the filter is ready, and
// the input waits until its last one issues; results pass stage 1, sequencer, f1, f2, output regs.
// the line store is one 3072 x 16 memory read at accept and written back when the word leaves
// the first stage; a same-entry read right behind a write is forwarded from the last-write
// register.
// synchronous active-high reset clears control state and window registers; no clearing pass.
// a stalled output backs up through the pipeline and drops req_chan.ready.
module window_3x3_mean_median_gaussian_unit import wmmg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   wmmg_req_if.sink               req_chan,
   wmmg_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [1:0]  chan_cnt_ff;
   logic [1:0]  mode_ff;

   logic [11:0] row_ff;
   logic [9:0]  col_ff;
   logic [1:0]  chan_ff;

   logic [10:0] w_lim;
   logic [12:0] h_lim;
   logic [1:0]  n_lim;
   logic        last_col;
   logic        last_row;
   logic        last_ch;
   logic        accept;
   logic [1:0]  k_sel;
   logic [LINE_ADDR_W-1:0] rd_addr;

   logic [15:0] line_mem [LINE_DEPTH];
   logic [15:0] rd_data_ff;

   logic                   s1_v_ff;
   logic [7:0]             s1_x_ff;
   logic [LINE_ADDR_W-1:0] s1_addr_ff;
   logic [1:0]             s1_k_ff;
   logic                   s1_rz_ff;
   logic                   s1_cz_ff;
   logic                   s1_lc_ff;
   logic                   s1_lr_ff;
   logic                   s1_lch_ff;

   logic                   lw_v_ff;
   logic [LINE_ADDR_W-1:0] lw_addr_ff;
   logic [15:0]            lw_data_ff;

   logic [7:0] win_ff [MAX_CHANNELS][3][3];
   logic [7:0] new_win [3][3];
   logic [15:0] line_word;
   logic [7:0]  top_pix;
   logic [7:0]  mid_pix;
   logic [3:0]  new_mask;
   logic        s1_adv;

   logic [3:0] s2_mask_ff;
   logic [7:0] s2_win_ff [3][3];
   logic       s2_frame_ff;
   logic [1:0] slot;
   logic [3:0] remaining;
   logic       issue;
   logic       s2_can_load;
   job_type    job;
   logic       f_ready;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd256;
         height_ff   <= 13'd256;
         chan_cnt_ff <= 2'd1;
         mode_ff     <= MODE_GAUSS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff    <= csr_wr_data[10:0];
            CSR_IMAGE_HEIGHT:  height_ff   <= csr_wr_data[12:0];
            CSR_CHANNEL_COUNT: chan_cnt_ff <= csr_wr_data[1:0];
            CSR_FILTER_MODE:   mode_ff     <= csr_wr_data[1:0];
            default:           mode_ff     <= mode_ff;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_lim = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         w_lim = 11'(MAX_WIDTH);
      end else begin
         w_lim = width_ff;
      end
      if (height_ff == '0) begin
         h_lim = 13'd1;
      end else if (height_ff > 13'(MAX_HEIGHT)) begin
         h_lim = 13'(MAX_HEIGHT);
      end else begin
         h_lim = height_ff;
      end
      if (chan_cnt_ff == '0) begin
         n_lim = 2'd1;
      end else if (chan_cnt_ff > 2'(MAX_CHANNELS)) begin
         n_lim = 2'(MAX_CHANNELS);
      end else begin
         n_lim = chan_cnt_ff;
      end
      last_col = {1'b0, col_ff} >= (w_lim - 11'd1);
      last_row = {1'b0, row_ff} >= (h_lim - 13'd1);
      last_ch  = chan_ff >= (n_lim - 2'd1);
      k_sel    = (chan_ff > 2'(MAX_CHANNELS - 1)) ? 2'(MAX_CHANNELS - 1) : chan_ff;
      // entry = column * 3 + channel
      rd_addr  = LINE_ADDR_W'({2'b00, col_ff} + {1'b0, col_ff, 1'b0} + {10'd0, k_sel});
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_v_ff || s2_can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         chan_ff <= '0;
      end else if (accept) begin
         if (last_ch) begin
            chan_ff <= '0;
            if (last_col) begin
               col_ff <= '0;
               row_ff <= last_row ? '0 : row_ff + 12'd1;
            end else begin
               col_ff <= col_ff + 10'd1;
            end
         end else begin
            chan_ff <= chan_ff + 2'd1;
         end
      end
   end

   // line store: older row in the high byte, newer row in the low byte
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (s1_adv) begin
         line_mem[s1_addr_ff] <= {mid_pix, s1_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff    <= req_chan.sample_in;
         s1_addr_ff <= rd_addr;
         s1_k_ff    <= k_sel;
         s1_rz_ff   <= (row_ff == '0);
         s1_cz_ff   <= (col_ff == '0);
         s1_lc_ff   <= last_col;
         s1_lr_ff   <= last_row;
         s1_lch_ff  <= last_ch;
      end
      if (s1_adv) begin
         lw_addr_ff <= s1_addr_ff;
         lw_data_ff <= {mid_pix, s1_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         lw_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_v_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_adv) begin
            lw_v_ff <= 1'b1;
         end
      end
   end

   // last write is the newest copy of its entry
   always_comb begin
      line_word = (lw_v_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : rd_data_ff;
      top_pix   = s1_rz_ff ? s1_x_ff : line_word[15:8];
      mid_pix   = s1_rz_ff ? s1_x_ff : line_word[7:0];
      for (int c = 0; c < 3; c++) begin
         if (s1_cz_ff || c == 2) begin
            new_win[c][0] = top_pix;
            new_win[c][1] = mid_pix;
            new_win[c][2] = s1_x_ff;
         end else begin
            for (int r = 0; r < 3; r++) begin
               new_win[c][r] = win_ff[s1_k_ff][c + 1][r];
            end
         end
      end
      new_mask = {s1_lr_ff & s1_lc_ff, s1_lr_ff & !s1_cz_ff,
                  !s1_rz_ff & s1_lc_ff, !s1_rz_ff & !s1_cz_ff};
   end

   assign s1_adv = s1_v_ff && s2_can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '{default: '0};
      end else if (s1_adv) begin
         win_ff[s1_k_ff] <= new_win;
      end
   end

   // result sequencer: upper row before last row, middle column before edge
   always_comb begin
      priority if (s2_mask_ff[0]) begin
         slot = 2'd0;
      end else if (s2_mask_ff[1]) begin
         slot = 2'd1;
      end else if (s2_mask_ff[2]) begin
         slot = 2'd2;
      end else begin
         slot = 2'd3;
      end
      remaining   = s2_mask_ff & ~(4'd1 << slot);
      issue       = (s2_mask_ff != '0) && f_ready;
      s2_can_load = (s2_mask_ff == '0) || (issue && (remaining == '0));
      for (int m = 0; m < 3; m++) begin
         for (int n = 0; n < 3; n++) begin
            job.pix[m * 3 + n] =
               s2_win_ff[slot[0] ? ((n == 0) ? 1 : 2) : n][slot[1] ? ((m == 0) ? 1 : 2) : m];
         end
      end
      job.run_last   = (remaining == '0);
      job.frame_last = (remaining == '0) && s2_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else if (s1_adv) begin
         s2_mask_ff <= new_mask;
      end else if (issue) begin
         s2_mask_ff <= remaining;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_win_ff   <= new_win;
         s2_frame_ff <= s1_lr_ff && s1_lc_ff && s1_lch_ff;
      end
   end

   wmmg_filter u_filter (
      .clock    (clock),
      .reset    (reset),
      .in_valid (issue),
      .in_ready (f_ready),
      .in_job   (job),
      .mode     (mode_ff),
      .rsp_chan (rsp_chan)
   );

endmodule

### design/wmmg_checker.sv
// port-level checks for the 3x3 window filter, bound to the top level
module wmmg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       run_last,
   input logic       frame_last
);

   // end of frame always closes a word's results
   a_frame_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_last |-> run_last)
      else $error("frame_last without run_last");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind window_3x3_mean_median_gaussian_unit wmmg_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .run_last   (rsp_chan.run_last),
   .frame_last (rsp_chan.frame_last)
);

### tb/window_3x3_mean_median_gaussian_unit_test.sv
// testbench for the 3x3 window filter: random frames, shadow filter, word-by-word compare
module window_3x3_mean_median_gaussian_unit_test;
   import wmmg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] value;
      logic       run_last;
      logic       frame_last;
   } filt_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   wmmg_req_if req ();
   wmmg_rsp_if rsp ();

   window_3x3_mean_median_gaussian_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // shadow of the block's registers and storage
   logic [10:0] img_width_reg;
   logic [12:0] img_height_reg;
   logic [1:0]  chan_count_reg;
   logic [1:0]  mode_reg;
   logic [7:0]  line_older [LINE_DEPTH];
   logic [7:0]  line_newer [LINE_DEPTH];
   logic [7:0]  win_pix [MAX_CHANNELS*9];
   int unsigned row_pos, col_pos, chan_pos;

   logic [7:0] pending_samples [$];
   filt_word_type filtered_expected [$];
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int frames_run = 0;
   int samples_queued = 0;
   int idle_cycles = 0;
   bit hold_request = 0;
   int gap_left = 0;
   int burst_left = 0;
   int hold_left = 0;
   int stall_style = 0;
   int cycle_count = 0;
   bit offer;
   bit rdy;

   function automatic logic [7:0] filter_nine(input logic [7:0] v [9]);
      int unsigned total;
      logic [7:0] s [9];
      logic [7:0] t;
      int j;
      total = 0;
      if (mode_reg == MODE_MEAN) begin
         for (int i = 0; i < 9; i++) total += v[i];
         return 8'(total / 9);
      end
      if (mode_reg == MODE_MEDIAN) begin
         s = v;
         for (int i = 1; i < 9; i++) begin
            t = s[i];
            j = i;
            while (j > 0 && s[j-1] > t) begin
               s[j] = s[j-1];
               j--;
            end
            s[j] = t;
         end
         return s[4];
      end
      total = v[0] + v[2] + v[6] + v[8] + 2 * (v[1] + v[3] + v[5] + v[7]) + 4 * v[4];
      return 8'(total / 16);
   endfunction

   // edge_col repeats the right column, bottom_row repeats the bottom row
   function automatic logic [7:0] window_value(input int k, input bit edge_col,
                                               input bit bottom_row);
      logic [7:0] v [9];
      int cc, rr;
      for (int m = 0; m < 3; m++)
         for (int n = 0; n < 3; n++) begin
            cc = edge_col ? ((n == 0) ? 1 : 2) : n;
            rr = bottom_row ? ((m == 0) ? 1 : 2) : m;
            v[m*3+n] = win_pix[k*9 + cc*3 + rr];
         end
      return filter_nine(v);
   endfunction

   task automatic filter_word(input logic [7:0] x);
      int unsigned w, h, nch, r, c, k, idx, base;
      bit lc, lr, lch;
      logic [7:0] top, mid;
      filt_word_type outs [4];
      int n;
      w   = (img_width_reg == 0) ? 1 : (img_width_reg > MAX_WIDTH) ? MAX_WIDTH : img_width_reg;
      h   = (img_height_reg == 0) ? 1 :
            (img_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : img_height_reg;
      nch = (chan_count_reg == 0) ? 1 :
            (chan_count_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_count_reg;
      r = row_pos; c = col_pos; k = chan_pos;
      lc = c >= w - 1; lr = r >= h - 1; lch = k >= nch - 1;
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      if (k >= MAX_CHANNELS) k = MAX_CHANNELS - 1;
      idx = c * MAX_CHANNELS + k;
      if (r == 0) begin
         top = x; mid = x;
      end else begin
         top = line_older[idx]; mid = line_newer[idx];
      end
      line_older[idx] = mid;
      line_newer[idx] = x;
      base = k * 9;
      if (c == 0) begin
         for (int i = 0; i < 3; i++) begin
            win_pix[base + i*3]     = top;
            win_pix[base + i*3 + 1] = mid;
            win_pix[base + i*3 + 2] = x;
         end
      end else begin
         for (int i = 0; i < 6; i++) win_pix[base + i] = win_pix[base + i + 3];
         win_pix[base + 6] = top;
         win_pix[base + 7] = mid;
         win_pix[base + 8] = x;
      end
      n = 0;
      // upper row first, then the last row when this is the bottom of the frame
      for (int pass = 0; pass < 2; pass++) begin
         if ((pass == 0 && r != 0) || (pass == 1 && lr)) begin
            if (c >= 1) begin
               outs[n] = '{window_value(k, 0, pass == 1), 1'b0, 1'b0};
               n++;
            end
            if (lc) begin
               outs[n] = '{window_value(k, 1, pass == 1), 1'b0, 1'b0};
               n++;
            end
         end
      end
      if (n > 0) begin
         outs[n-1].run_last = 1'b1;
         if (lr && lc && lch) outs[n-1].frame_last = 1'b1;
      end
      for (int i = 0; i < n; i++) filtered_expected.insert(filtered_expected.size(), outs[i]);
      if (lch) begin
         chan_pos = 0;
         if (lc) begin
            col_pos = 0;
            row_pos = lr ? 0 : row_pos + 1;
         end else begin
            col_pos = col_pos + 1;
         end
      end else begin
         chan_pos = chan_pos + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch on result word %0d: %s got %0d expected %0d", words_out, what, got,
               want);
   endtask

   // sender: bursts and gaps; a word on offer stays until taken
   always @(posedge clock) begin
      if (reset) begin
         req.valid     <= 1'b0;
         req.sample_in <= '0;
      end else begin
         if (req.valid && req.ready) begin
            filter_word(req.sample_in);
            void'(pending_samples.pop_front());
            words_in++;
         end
         offer = 0;
         if (req.valid && !req.ready) begin
            offer = 1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_samples.size() > 0) begin
            offer = 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end
         req.valid <= offer;
         if (offer && !(req.valid && !req.ready)) req.sample_in <= pending_samples[0];
      end
   end

   // receiver: checks words and stalls on a randomly chosen pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp.valid && rsp.ready) begin
            if (filtered_expected.size() == 0) begin
               report_mismatch("unexpected word", rsp.sample_out, 0);
            end else begin
               if (rsp.sample_out !== filtered_expected[0].value)
                  report_mismatch("sample_out", rsp.sample_out, filtered_expected[0].value);
               if (rsp.run_last !== filtered_expected[0].run_last)
                  report_mismatch("run_last", rsp.run_last, filtered_expected[0].run_last);
               if (rsp.frame_last !== filtered_expected[0].frame_last)
                  report_mismatch("frame_last", rsp.frame_last,
                                  filtered_expected[0].frame_last);
               void'(filtered_expected.pop_front());
            end
            words_out++;
         end
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("timeout: nothing moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
         end
         if (cycle_count % 64 == 0) stall_style = $urandom_range(0, 3);
         if (hold_request && hold_left == 0) begin
            hold_left = 180;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 0;
         end else begin
            case (stall_style)
               0: rdy = 1;
               1: rdy = ($urandom_range(0, 9) >= 3);
               2: rdy = (cycle_count % 5 != 0);
               default: rdy = ($urandom_range(0, 1) == 1);
            endcase
         end
         rsp.ready <= rdy;
      end
   end

   task automatic wait_idle();
      while (pending_samples.size() > 0 || req.valid || filtered_expected.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:   img_width_reg  = 11'(value);
         CSR_IMAGE_HEIGHT:  img_height_reg = 13'(value);
         CSR_CHANNEL_COUNT: chan_count_reg = 2'(value);
         default:           mode_reg       = 2'(value);
      endcase
   endtask

   // fill: 0 random, 1 all zero, 2 all 255, 3 alternating 0/255
   task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned nch,
                            input int unsigned mode, input int fill, input bit split);
      int unsigned total, cw, ch, cn;
      logic [7:0] b;
      wait_idle();
      @(posedge clock);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_CHANNEL_COUNT, nch);
      write_csr(CSR_FILTER_MODE, mode);
      cw = (img_width_reg == 0) ? 1 : (img_width_reg > MAX_WIDTH) ? MAX_WIDTH : img_width_reg;
      ch = (img_height_reg == 0) ? 1 :
           (img_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : img_height_reg;
      cn = (chan_count_reg == 0) ? 1 : chan_count_reg;
      total = cw * ch * cn;
      for (int unsigned i = 0; i < total; i++) begin
         case (fill)
            1: b = 8'h00;
            2: b = 8'hff;
            3: b = i[0] ? 8'hff : 8'h00;
            default: b = 8'($urandom);
         endcase
         // pause mid-frame until everything owed so far has come out
         if (split && i == total / 2) wait_idle();
         pending_samples.insert(pending_samples.size(), b);
         samples_queued++;
      end
      frames_run++;
   endtask

   initial begin
      int unsigned w, h, nch, sel;
      req.valid     = 1'b0;
      req.sample_in = '0;
      rsp.ready     = 1'b0;
      img_width_reg  = 11'd256;
      img_height_reg = 13'd256;
      chan_count_reg = 2'd1;
      mode_reg       = MODE_GAUSS;
      for (int i = 0; i < MAX_CHANNELS*9; i++) win_pix[i] = '0;
      row_pos = 0; col_pos = 0; chan_pos = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames: single pixel, extremes, every mode, border cases
      run_frame(1, 1, 1, MODE_MEAN, 2, 0);
      run_frame(3, 1, 1, MODE_MEDIAN, 0, 0);
      run_frame(1, 3, 1, MODE_GAUSS, 0, 0);
      run_frame(2, 2, 1, MODE_MEAN, 3, 0);
      run_frame(2, 2, 3, MODE_MEDIAN, 0, 0);
      run_frame(1, 2, 2, MODE_GAUSS_ALT, 1, 0);
      run_frame(0, 0, 0, MODE_GAUSS, 2, 0);

      // receiver holds off while this frame is offered, so the block backs up
      run_frame(8, 4, 1, MODE_MEDIAN, 0, 0);
      hold_request = 1;

      // random frames, mostly small
      while (samples_queued < 420) begin
         sel = $urandom_range(0, 19);
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 6);
         nch = $urandom_range(0, 3);
         if (sel == 0) w = 0;
         if (sel == 1) h = 0;
         run_frame(w, h, nch, $urandom_range(0, 3), 0, frames_run == 12);
      end

      // every channel in use
      run_frame(3, 3, MAX_CHANNELS, MODE_GAUSS, 0, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d frames, %0d samples in, %0d filtered words out", frames_run,
               words_in, words_out);
      $display("all modes, border replication, clamped registers, stalls and backpressure");
      if (errors == 0 && filtered_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
design/wmmg_pkg.sv
design/wmmg_req_if.sv
design/wmmg_rsp_if.sv
design/wmmg_filter.sv
design/window_3x3_mean_median_gaussian_unit.sv
design/wmmg_checker.sv
tb/window_3x3_mean_median_gaussian_unit_test.sv
